/* rtl/core/rfcuuid_pkg.sv */
`default_nettype none

package rfcuuid_pkg;

  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CfgSeedInit   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxPerTick = 1'b1;

  localparam logic [15:0] MaxPerTickRst = 16'd1024;
  localparam logic [31:0] SeedRst       = 32'd1;

  localparam logic [30:0] LcgMul      = 31'd1103515245;
  localparam logic [31:0] LcgAdd      = 32'd12345;
  localparam logic [32:0] EpochSecs   = 33'd2922;
  localparam logic [30:0] TicksPerSec = 31'd10000000;
  localparam logic [63:0] GregOffset  = 64'h01B2_1DD2_1381_4000;

  localparam logic [3:0] VerTime   = 4'h1;
  localparam logic [3:0] VerRandom = 4'h4;
  localparam logic [1:0] VariantBits = 2'b10;

  typedef enum logic [1:0] {
    MUL_LCG  = 2'b01,
    MUL_TICK = 2'b10
  } mul_op_e;

  typedef struct packed {
    mul_op_e     op;
    logic [32:0] a;
  } mul_req_t;

  typedef struct packed {
    logic        action;
    logic [31:0] time_seconds;
    logic [19:0] time_micros;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [31:0] time_low_part;
    logic [15:0] time_mid_part;
    logic [15:0] time_hi_version;
    logic [7:0]  clock_seq_hi_variant;
    logic [7:0]  clock_seq_lo;
    logic [47:0] node_id;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/rfcuuid_if.sv */
`default_nettype none

interface rfcuuid_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] time_seconds;
  logic [19:0] time_micros;

  modport source (output valid, action, time_seconds, time_micros, input ready);
  modport sink (input valid, action, time_seconds, time_micros, output ready);
endinterface

interface rfcuuid_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [31:0] time_low_part;
  logic [15:0] time_mid_part;
  logic [15:0] time_hi_version;
  logic [7:0]  clock_seq_hi_variant;
  logic [7:0]  clock_seq_lo;
  logic [47:0] node_id;

  modport source (
    output valid, status, time_low_part, time_mid_part, time_hi_version,
           clock_seq_hi_variant, clock_seq_lo, node_id,
    input  ready
  );
  modport sink (
    input  valid, status, time_low_part, time_mid_part, time_hi_version,
           clock_seq_hi_variant, clock_seq_lo, node_id,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/rfcuuid_mul.sv */
`default_nettype none

module rfcuuid_mul
  import rfcuuid_pkg::*;
(
  input  wire logic     clk_i,
  input  wire mul_req_t mul_i,
  output logic [63:0]   prod_o
);

  logic [30:0] b;
  logic [63:0] prod_d, prod_q;

  always_comb begin
    unique case (mul_i.op)
      MUL_LCG:  b = LcgMul;
      MUL_TICK: b = TicksPerSec;
      default:  b = LcgMul;
    endcase
    prod_d = {31'b0, mul_i.a} * {33'b0, b};
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

/* rtl/core/rfcuuid_ctrl.sv */
`default_nettype none

module rfcuuid_ctrl
  import rfcuuid_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        req_fire_i,
  input  wire req_t        req_i,
  input  wire logic        seed_we_i,
  input  wire logic [31:0] seed_i,
  input  wire logic [15:0] max_per_tick_i,
  input  wire logic        out_free_i,
  input  wire logic [63:0] prod_i,
  output logic             idle_o,
  output logic             res_push_o,
  output res_t             res_o,
  output mul_req_t         mul_o
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_DRAW_A = 10'b00_0000_0010,
    ST_DRAW_B = 10'b00_0000_0100,
    ST_T_MUL  = 10'b00_0000_1000,
    ST_T_ADD1 = 10'b00_0001_0000,
    ST_T_ADD2 = 10'b00_0010_0000,
    ST_T_CHK  = 10'b00_0100_0000,
    ST_T_SUM  = 10'b00_1000_0000,
    ST_T_CMP  = 10'b01_0000_0000,
    ST_DONE   = 10'b10_0000_0000
  } state_e;

  state_e       state_d, state_q;
  logic [31:0]  seed_d, seed_q;
  logic [63:0]  last_d, last_q;
  logic [15:0]  rc_d, rc_q;
  logic         ready_d, ready_q;
  logic [15:0]  scs_d, scs_q;
  logic [63:0]  sts_d, sts_q;
  logic [47:0]  node_d, node_q;
  logic [3:0]   cnt_d, cnt_q;
  logic         act_d, act_q;
  logic [31:0]  secs_d, secs_q;
  logic [19:0]  us_d, us_q;
  logic [63:0]  now_d, now_q;
  logic [63:0]  t_d, t_q;
  logic [127:0] buf_d, buf_q;
  res_t         res_d, res_q;

  logic [31:0] seed_n;
  logic [1:0]  adj;
  logic [15:0] draw16;
  logic [15:0] cs_n;

  always_comb begin
    seed_n = prod_i[31:0] + LcgAdd;
    priority if (&seed_n[31:1]) begin
      adj = 2'd2;
    end else if (seed_n[31] || (seed_n == 32'h7FFF_FFFF)) begin
      adj = 2'd1;
    end else begin
      adj = 2'd0;
    end
    // low bits of seed mod (2^31-1): subtracting k*(2^31-1) adds k mod 2^16
    draw16 = seed_n[15:0] + {14'b0, adj};
    cs_n   = scs_q + {15'b0, (t_q < sts_q)};
  end

  always_comb begin
    state_d = state_q;
    seed_d  = seed_q;
    last_d  = last_q;
    rc_d    = rc_q;
    ready_d = ready_q;
    scs_d   = scs_q;
    sts_d   = sts_q;
    node_d  = node_q;
    cnt_d   = cnt_q;
    act_d   = act_q;
    secs_d  = secs_q;
    us_d    = us_q;
    now_d   = now_q;
    t_d     = t_q;
    buf_d   = buf_q;
    res_d   = res_q;
    mul_o.op = MUL_LCG;
    mul_o.a  = {1'b0, seed_q};
    res_push_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (seed_we_i) begin
          seed_d = seed_i;
        end
        if (req_fire_i) begin
          act_d  = req_i.action;
          secs_d = req_i.time_seconds;
          us_d   = req_i.time_micros;
          cnt_d  = 4'd15;
          state_d = req_i.action ? ST_T_MUL : ST_DRAW_A;
        end
      end
      ST_DRAW_A: begin
        state_d = ST_DRAW_B;
      end
      ST_DRAW_B: begin
        seed_d = seed_n;
        if (act_q && (cnt_q == 4'd6)) begin
          scs_d = draw16;
        end else begin
          buf_d = {buf_q[119:0], draw16[7:0]};
        end
        if (cnt_q == 4'd0) begin
          if (act_q) begin
            node_d  = buf_d[47:0] | (48'h1 << 40);
            ready_d = 1'b1;
            state_d = ST_T_CMP;
          end else begin
            res_d.status               = 1'b0;
            res_d.time_low_part        = buf_d[127:96];
            res_d.time_mid_part        = buf_d[95:80];
            res_d.time_hi_version      = {VerRandom, buf_d[75:64]};
            res_d.clock_seq_hi_variant = {VariantBits, buf_d[61:56]};
            res_d.clock_seq_lo         = buf_d[55:48];
            res_d.node_id              = buf_d[47:0];
            state_d = ST_DONE;
          end
        end else begin
          cnt_d   = cnt_q - 4'd1;
          state_d = ST_DRAW_A;
        end
      end
      ST_T_MUL: begin
        mul_o.op = MUL_TICK;
        mul_o.a  = {1'b0, secs_q} + EpochSecs;
        state_d  = ST_T_ADD1;
      end
      ST_T_ADD1: begin
        now_d   = prod_i + ({44'b0, us_q} << 3) + ({44'b0, us_q} << 1);
        state_d = ST_T_ADD2;
      end
      ST_T_ADD2: begin
        now_d   = now_q + GregOffset;
        state_d = ST_T_CHK;
      end
      ST_T_CHK: begin
        if (now_q != last_q) begin
          rc_d    = 16'd0;
          last_d  = now_q;
          state_d = ST_T_SUM;
        end else if (rc_q < max_per_tick_i) begin
          rc_d    = rc_q + 16'd1;
          state_d = ST_T_SUM;
        end else begin
          res_d        = '0;
          res_d.status = 1'b1;
          state_d      = ST_DONE;
        end
      end
      ST_T_SUM: begin
        t_d = last_q + {48'b0, rc_q};
        if (!ready_q) begin
          sts_d   = last_q;
          cnt_d   = 4'd6;
          state_d = ST_DRAW_A;
        end else begin
          state_d = ST_T_CMP;
        end
      end
      ST_T_CMP: begin
        scs_d = cs_n;
        sts_d = t_q;
        res_d.status               = 1'b0;
        res_d.time_low_part        = t_q[31:0];
        res_d.time_mid_part        = t_q[47:32];
        res_d.time_hi_version      = {VerTime, t_q[59:48]};
        res_d.clock_seq_hi_variant = {VariantBits, cs_n[13:8]};
        res_d.clock_seq_lo         = cs_n[7:0];
        res_d.node_id              = node_q;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) begin
          res_push_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seed_q  <= SeedRst;
      last_q  <= '0;
      rc_q    <= '0;
      ready_q <= 1'b0;
      scs_q   <= '0;
      sts_q   <= '0;
      node_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      seed_q  <= seed_d;
      last_q  <= last_d;
      rc_q    <= rc_d;
      ready_q <= ready_d;
      scs_q   <= scs_d;
      sts_q   <= sts_d;
      node_q  <= node_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    secs_q <= secs_d;
    us_q   <= us_d;
    now_q  <= now_d;
    t_q    <= t_d;
    buf_q  <= buf_d;
    res_q  <= res_d;
  end

  assign idle_o = (state_q == ST_IDLE);
  assign res_o  = res_q;

  a_retry_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_q.status) |-> (res_q.time_low_part == '0 &&
      res_q.time_hi_version == '0 && res_q.node_id == '0 &&
      res_q.clock_seq_hi_variant == '0))
    else $error("retry item carries nonzero fields");

  a_version: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && !res_q.status) |->
      ((res_q.time_hi_version[15:12] == VerTime ||
        res_q.time_hi_version[15:12] == VerRandom) &&
       res_q.clock_seq_hi_variant[7:6] == VariantBits))
    else $error("bad version or variant bits");

  a_ready_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |=> ready_q)
    else $error("time state lost its init flag");

  a_init_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAW_B && cnt_q == 4'd0 && act_q) |=>
      (ready_q && node_q[40] && state_q == ST_T_CMP))
    else $error("node init did not complete");

endmodule

`default_nettype wire

/* rtl/core/rfcuuid_ctrl_top_dummy_placeholder_removed.sv */
`default_nettype none

module rfcuuid_outreg
  import rfcuuid_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire res_t res_i,
  input  wire logic take_i,
  output logic      free_o,
  output logic      valid_o,
  output res_t      res_o
);

  logic vld_d, vld_q;
  res_t res_q;

  always_comb begin
    vld_d = vld_q;
    if (push_i) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign free_o  = !vld_q || take_i;
  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

/* rtl/core/rfc4122_uuid_generator.sv */
// RFC 4122 identifier generator, version 4 (random) and version 1 (time).
// Request channel req_i: action selects random (0) or time based (1);
// time_seconds / time_micros are used in time mode only. One item in gives
// one item out on rsp_o. status 1 means the repeat limit for the current
// timestamp is reached; all other fields are then zero and no state moves.
// Config port: cfg_we_i with cfg_idx_i 0 loads seed_init into the generator
// seed at once, index 1 sets max_per_tick. Write only while idle.
// The next request is accepted once the result has been loaded into the
// output register and the core is back in idle. Every random byte is one
// generator step on the single shared 33x31 multiplier, which also forms
// the 100 ns tick count; one item is in flight at a time.
// Reset clears the timestamp history and the node/clock sequence, so the
// first time request draws them anew; the seed returns to 1.
// A finished item sits in the output register while the next request is
// accepted; if rsp_o stays stalled the core holds its result and waits.
`default_nettype none

module rfc4122_uuid_generator
  import rfcuuid_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i,
  rfcuuid_req_if.sink             req_i,
  rfcuuid_rsp_if.source           rsp_o
);

  logic        idle;
  logic        req_fire;
  req_t        req;
  logic [15:0] mpt_q;
  logic        seed_we;
  logic        out_free;
  logic        res_push;
  res_t        res;
  res_t        rsp;
  mul_req_t    mul_req;
  logic [63:0] prod;

  assign req_i.ready = idle;
  assign req_fire    = req_i.valid && idle;
  assign req.action       = req_i.action;
  assign req.time_seconds = req_i.time_seconds;
  assign req.time_micros  = req_i.time_micros;

  assign seed_we = cfg_we_i && (cfg_idx_i == CfgSeedInit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mpt_q <= MaxPerTickRst;
    end else if (cfg_we_i && (cfg_idx_i == CfgMaxPerTick)) begin
      mpt_q <= cfg_data_i[15:0];
    end
  end

  rfcuuid_mul u_mul (
    .clk_i  (clk_i),
    .mul_i  (mul_req),
    .prod_o (prod)
  );

  rfcuuid_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_fire_i     (req_fire),
    .req_i          (req),
    .seed_we_i      (seed_we),
    .seed_i         (cfg_data_i),
    .max_per_tick_i (mpt_q),
    .out_free_i     (out_free),
    .prod_i         (prod),
    .idle_o         (idle),
    .res_push_o     (res_push),
    .res_o          (res),
    .mul_o          (mul_req)
  );

  rfcuuid_outreg u_outreg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res),
    .take_i  (rsp_o.ready),
    .free_o  (out_free),
    .valid_o (rsp_o.valid),
    .res_o   (rsp)
  );

  assign rsp_o.status               = rsp.status;
  assign rsp_o.time_low_part        = rsp.time_low_part;
  assign rsp_o.time_mid_part        = rsp.time_mid_part;
  assign rsp_o.time_hi_version      = rsp.time_hi_version;
  assign rsp_o.clock_seq_hi_variant = rsp.clock_seq_hi_variant;
  assign rsp_o.clock_seq_lo         = rsp.clock_seq_lo;
  assign rsp_o.node_id              = rsp.node_id;

endmodule

`default_nettype wire
